// File: hdl/rcc_pkg.sv
// shared constants, codes and control types of the regional cross-correlation block
`default_nettype none
package rcc_pkg;

    localparam int unsigned MAX_SAMPLES = 65536;
    localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int unsigned COUNT_W     = ADDR_W + 1;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned SUM_W       = 33;
    localparam int unsigned MEAN_W      = 25;
    localparam int unsigned DEV_W       = 26;
    localparam int unsigned PROD_W      = 2 * DEV_W;
    localparam int unsigned ACC_W       = 56;
    localparam int unsigned ROOT_W      = ACC_W / 2;
    localparam int unsigned DIVD_W      = ACC_W + 16;
    localparam int unsigned DIVS_W      = ACC_W;
    localparam int unsigned VAL_W       = 20;
    localparam int unsigned TOTAL_W     = 24;
    localparam int unsigned CORR_W      = 16;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned LAG_W       = 3;
    localparam int unsigned WIN_W       = 4;
    localparam int unsigned OFF_W       = WIN_W + 1;
    localparam int unsigned LAGC_W      = LAG_W + 1;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [LAG_W-1:0] LAG_SPAN_RESET   = 3'd3;
    localparam logic [WIN_W-1:0] WINDOW_END_RESET = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_LAG_SPAN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END = 1'b1;

    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VALUE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOREG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_LOAD,
        OP_QINIT,
        OP_MEANX,
        OP_MEANY,
        OP_STOP_INIT,
        OP_LAG_INIT,
        OP_READ,
        OP_DEV,
        OP_MUL,
        OP_ACC,
        OP_SQX_START,
        OP_SQX_DONE,
        OP_SQY_DONE,
        OP_DMUL,
        OP_DIV_START,
        OP_LAG_DONE,
        OP_AVG_START,
        OP_AVG_DONE,
        OP_EMIT_NOREG,
        OP_EMIT_ZERO,
        OP_EMIT_VALUE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } rcc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic sqrt_done;
        logic cur_ok;
        logic nxt_ok;
        logic sample_last;
        logic lag_last;
        logic zero_energy;
    } rcc_stat_t;

endpackage
`default_nettype wire

// File: hdl/rcc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rcc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/rcc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module rcc_div
    import rcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic      [DIVD_W-1:0] quotient,
    output logic                   done
);

    localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W+1:0] diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = !diff[DIVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quo_reg  <= dividend;
            cnt_reg  <= CNT_W'(DIVD_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

// File: hdl/rcc_sqrt.sv
// integer square root rounded down, two radicand bits per cycle
`default_nettype none
module rcc_sqrt
    import rcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root,
    output logic                   done
);

    logic [ACC_W-1:0] v_reg;
    logic [ACC_W-1:0] r_reg;
    logic [ACC_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            v_reg    <= radicand;
            r_reg    <= '0;
            bit_reg  <= ACC_W'(1) << (ACC_W - 2);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (bit_reg == ACC_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign root = r_reg[ROOT_W-1:0];
    assign done = done_reg;

endmodule
`default_nettype wire

// File: hdl/rcc_ctrl.sv
// sequencer for load, clear and query items
`default_nettype none
module rcc_ctrl
    import rcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic [FUNC_W-1:0] s_func,
    output logic                   s_ready,
    input  wire rcc_stat_t         stat,
    output rcc_cmd_t               cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_QINIT, S_WAIT_MX, S_WAIT_MY, S_CHECK, S_NOREG,
        S_STOP_INIT, S_LAG_INIT, S_READ, S_DEV, S_MUL, S_ACC, S_ZCHK,
        S_SQX, S_SQY, S_DMUL, S_DIVS, S_DIVW, S_AVGS, S_AVGW, S_EMITV, S_EMITZ
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    priority if (s_func == FN_LOAD) begin
                        cmd.op     = OP_CAPTURE;
                        state_next = S_LOAD;
                    end else if (s_func == FN_QUERY) begin
                        cmd.op     = OP_CAPTURE;
                        state_next = S_QINIT;
                    end else if (s_func == FN_CLEAR) begin
                        cmd.op = OP_CLEAR;
                    end else begin
                        cmd.op = OP_NONE;
                    end
                end
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            S_QINIT: begin
                cmd.op     = OP_QINIT;
                state_next = S_WAIT_MX;
            end
            S_WAIT_MX: begin
                if (stat.div_done) begin
                    cmd.op     = OP_MEANX;
                    state_next = S_WAIT_MY;
                end
            end
            S_WAIT_MY: begin
                if (stat.div_done) begin
                    cmd.op     = OP_MEANY;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = stat.cur_ok ? S_STOP_INIT : S_NOREG;
            end
            S_NOREG: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_NOREG;
                    state_next = S_IDLE;
                end
            end
            S_STOP_INIT: begin
                cmd.op     = OP_STOP_INIT;
                state_next = S_LAG_INIT;
            end
            S_LAG_INIT: begin
                cmd.op     = OP_LAG_INIT;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.op     = OP_READ;
                state_next = S_DEV;
            end
            S_DEV: begin
                cmd.op     = OP_DEV;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.op     = OP_MUL;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = stat.sample_last ? S_ZCHK : S_READ;
            end
            S_ZCHK: begin
                if (stat.zero_energy) begin
                    state_next = S_EMITZ;
                end else begin
                    cmd.op     = OP_SQX_START;
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                if (stat.sqrt_done) begin
                    cmd.op     = OP_SQX_DONE;
                    state_next = S_SQY;
                end
            end
            S_SQY: begin
                if (stat.sqrt_done) begin
                    cmd.op     = OP_SQY_DONE;
                    state_next = S_DMUL;
                end
            end
            S_DMUL: begin
                cmd.op     = OP_DMUL;
                state_next = S_DIVS;
            end
            S_DIVS: begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.op     = OP_LAG_DONE;
                    state_next = stat.lag_last ? S_AVGS : S_LAG_INIT;
                end
            end
            S_AVGS: begin
                cmd.op     = OP_AVG_START;
                state_next = S_AVGW;
            end
            S_AVGW: begin
                if (stat.div_done) begin
                    cmd.op     = OP_AVG_DONE;
                    state_next = S_EMITV;
                end
            end
            S_EMITV: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_VALUE;
                    state_next = stat.nxt_ok ? S_STOP_INIT : S_IDLE;
                end
            end
            S_EMITZ: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_ZERO;
                    state_next = stat.nxt_ok ? S_STOP_INIT : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/rcc_dp.sv
// datapath: sample store, running sums, correlation arithmetic and result register
`default_nettype none
module rcc_dp
    import rcc_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire rcc_cmd_t                    cmd,
    output rcc_stat_t                        stat,
    input  wire logic signed [SAMPLE_W-1:0]  s_sample_x,
    input  wire logic signed [SAMPLE_W-1:0]  s_sample_y,
    input  wire logic        [ADDR_W-1:0]    s_start_index,
    input  wire logic                        cfg_valid,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [WIN_W-1:0]     cfg_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic             [ADDR_W-1:0]    m_stop_index,
    output logic signed      [CORR_W-1:0]    m_correlation,
    output logic             [STATUS_W-1:0]  m_status,
    output logic                             m_last
);

    logic [LAG_W-1:0]  lag_span_reg;
    logic [WIN_W-1:0]  window_end_reg;
    logic [COUNT_W-1:0] count_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;

    logic [SAMPLE_W-1:0] in_x_reg, in_y_reg;
    logic [ADDR_W-1:0]   in_s_reg;

    logic [LAG_W-1:0]   span_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [LAGC_W-1:0]  lag_reg;
    logic [COUNT_W-1:0] i_reg;
    logic signed [MEAN_W-1:0] mx_reg, my_reg;
    logic signed [DEV_W-1:0]  dx_reg, dy_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [ACC_W-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic [ROOT_W-1:0]  rx_reg, ry_reg;
    logic [DIVS_W-1:0]  d_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [CORR_W-1:0]  avg_reg;

    logic                 m_valid_reg;
    logic [ADDR_W-1:0]    m_stop_reg;
    logic [CORR_W-1:0]    m_corr_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic                 m_last_reg;

    logic [SAMPLE_W-1:0] x_q, y_q;
    logic                full;
    logic                out_free;
    logic [COUNT_W-1:0]  cur_stop, nxt_stop, j_idx;
    logic [OFF_W-1:0]    nxt_off;
    logic                cur_ok, nxt_ok;
    logic                ram_we, ram_re;

    logic                div_start, sqrt_start;
    logic [DIVD_W-1:0]   div_dividend, div_quotient;
    logic [DIVS_W-1:0]   div_divisor;
    logic                div_done, sqrt_done;
    logic [ACC_W-1:0]    sqrt_in;
    logic [ROOT_W-1:0]   sqrt_root;

    logic [SUM_W-1:0]    sum_x_mag, sum_y_mag;
    logic [ACC_W-1:0]    sxy_mag;
    logic [TOTAL_W-1:0]  total_mag;
    logic [LAGC_W-1:0]   n_avg;
    logic signed [MEAN_W-1:0]  mean_val;
    logic [VAL_W-1:0]    half_q;
    logic signed [VAL_W-1:0]   lag_val;
    logic signed [TOTAL_W-1:0] avg_full;
    logic signed [CORR_W-1:0]  avg_sat;

    assign full     = (count_reg == COUNT_W'(MAX_SAMPLES));
    assign out_free = !m_valid_reg || m_ready;
    assign cur_stop = COUNT_W'(in_s_reg) + COUNT_W'(off_reg);
    assign nxt_off  = off_reg + 1'b1;
    assign nxt_stop = cur_stop + 1'b1;
    assign cur_ok   = (off_reg <= OFF_W'(window_end_reg)) && (nxt_stop < count_reg);
    assign nxt_ok   = (nxt_off <= OFF_W'(window_end_reg))
                      && ((nxt_stop + 1'b1) < count_reg);
    assign j_idx    = i_reg + COUNT_W'(lag_reg);

    assign ram_we = (cmd.op == OP_LOAD) && !full;
    assign ram_re = (cmd.op == OP_READ);

    rcc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_x_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_x_reg),
        .re    (ram_re),
        .raddr (i_reg[ADDR_W-1:0]),
        .rdata (x_q)
    );

    rcc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_y_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_y_reg),
        .re    (ram_re),
        .raddr (j_idx[ADDR_W-1:0]),
        .rdata (y_q)
    );

    assign sum_x_mag = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign sum_y_mag = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign sxy_mag   = sxy_reg[ACC_W-1] ? ACC_W'(-sxy_reg) : ACC_W'(sxy_reg);
    assign total_mag = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
    assign n_avg     = LAGC_W'(span_reg) + 1'b1;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd.op)
            OP_QINIT: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'({sum_x_mag, 9'b0}) + DIVD_W'(count_reg);
                div_divisor  = DIVS_W'({count_reg, 1'b0});
            end
            OP_MEANX: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'({sum_y_mag, 9'b0}) + DIVD_W'(count_reg);
                div_divisor  = DIVS_W'({count_reg, 1'b0});
            end
            OP_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = {sxy_mag, 16'b0};
                div_divisor  = d_reg;
            end
            OP_AVG_START: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'({total_mag, 1'b0}) + DIVD_W'(n_avg);
                div_divisor  = DIVS_W'({n_avg, 1'b0});
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (cmd.op == OP_SQX_START) || (cmd.op == OP_SQX_DONE);
    assign sqrt_in    = (cmd.op == OP_SQX_START) ? ACC_W'(sxx_reg) : ACC_W'(syy_reg);

    rcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    rcc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    // mean to 8 fraction bits, zero on an empty store
    always_comb begin
        logic signed [SUM_W-1:0] src;
        src      = (cmd.op == OP_MEANX) ? sum_x_reg : sum_y_reg;
        mean_val = MEAN_W'(div_quotient[MEAN_W-1:0]);
        if (src[SUM_W-1]) begin
            mean_val = -mean_val;
        end
        if (count_reg == '0) begin
            mean_val = '0;
        end
    end

    assign half_q  = (div_quotient[VAL_W-1:0] + 1'b1) >> 1;
    assign lag_val = sxy_reg[ACC_W-1] ? -$signed(half_q) : $signed(half_q);

    always_comb begin
        avg_full = $signed(div_quotient[TOTAL_W-1:0]);
        if (total_reg[TOTAL_W-1]) begin
            avg_full = -avg_full;
        end
        priority if (avg_full > TOTAL_W'(32767)) begin
            avg_sat = 16'sd32767;
        end else if (avg_full < -TOTAL_W'(32768)) begin
            avg_sat = -16'sd32768;
        end else begin
            avg_sat = avg_full[CORR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_span_reg   <= LAG_SPAN_RESET;
            window_end_reg <= WINDOW_END_RESET;
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LAG_SPAN:   lag_span_reg   <= cfg_data[LAG_W-1:0];
                    CFG_WINDOW_END: window_end_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_CLEAR) begin
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end
            if (ram_we) begin
                count_reg <= count_reg + 1'b1;
                sum_x_reg <= sum_x_reg + SUM_W'($signed(in_x_reg));
                sum_y_reg <= sum_y_reg + SUM_W'($signed(in_y_reg));
            end
            if ((cmd.op == OP_LOAD) || (cmd.op == OP_EMIT_NOREG)
                || (cmd.op == OP_EMIT_ZERO) || (cmd.op == OP_EMIT_VALUE)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_CAPTURE: begin
                in_x_reg <= s_sample_x;
                in_y_reg <= s_sample_y;
                in_s_reg <= s_start_index;
            end
            OP_LOAD: begin
                m_stop_reg   <= '0;
                m_corr_reg   <= '0;
                m_status_reg <= full ? ST_FULL : ST_STORED;
                m_last_reg   <= 1'b1;
            end
            OP_QINIT: begin
                span_reg <= (lag_span_reg == '0) ? LAG_W'(1) : lag_span_reg;
                off_reg  <= (lag_span_reg == '0) ? OFF_W'(1) : OFF_W'(lag_span_reg);
            end
            OP_MEANX: mx_reg <= mean_val;
            OP_MEANY: my_reg <= mean_val;
            OP_STOP_INIT: begin
                lag_reg   <= '0;
                total_reg <= '0;
            end
            OP_LAG_INIT: begin
                i_reg   <= COUNT_W'(in_s_reg);
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
            end
            OP_DEV: begin
                dx_reg <= DEV_W'($signed({x_q, 8'b0})) - DEV_W'(mx_reg);
                dy_reg <= DEV_W'($signed({y_q, 8'b0})) - DEV_W'(my_reg);
            end
            OP_MUL: begin
                pxx_reg <= dx_reg * dx_reg;
                pyy_reg <= dy_reg * dy_reg;
                pxy_reg <= dx_reg * dy_reg;
            end
            OP_ACC: begin
                sxx_reg <= sxx_reg + ACC_W'(pxx_reg);
                syy_reg <= syy_reg + ACC_W'(pyy_reg);
                sxy_reg <= sxy_reg + ACC_W'(pxy_reg);
                i_reg   <= i_reg + 1'b1;
            end
            OP_SQX_DONE: rx_reg <= sqrt_root;
            OP_SQY_DONE: ry_reg <= sqrt_root;
            OP_DMUL:     d_reg  <= rx_reg * ry_reg;
            OP_LAG_DONE: begin
                total_reg <= total_reg + TOTAL_W'(lag_val);
                lag_reg   <= lag_reg + 1'b1;
            end
            OP_AVG_DONE: avg_reg <= avg_sat;
            OP_EMIT_NOREG: begin
                m_stop_reg   <= '0;
                m_corr_reg   <= '0;
                m_status_reg <= ST_NOREG;
                m_last_reg   <= 1'b1;
            end
            OP_EMIT_ZERO: begin
                m_stop_reg   <= cur_stop[ADDR_W-1:0];
                m_corr_reg   <= '0;
                m_status_reg <= ST_ZERO;
                m_last_reg   <= !nxt_ok;
                off_reg      <= nxt_off;
            end
            OP_EMIT_VALUE: begin
                m_stop_reg   <= cur_stop[ADDR_W-1:0];
                m_corr_reg   <= avg_reg;
                m_status_reg <= ST_VALUE;
                m_last_reg   <= !nxt_ok;
                off_reg      <= nxt_off;
            end
            default: ;
        endcase
    end

    assign stat.out_free    = out_free;
    assign stat.div_done    = div_done;
    assign stat.sqrt_done   = sqrt_done;
    assign stat.cur_ok      = cur_ok;
    assign stat.nxt_ok      = nxt_ok;
    assign stat.sample_last = (j_idx == cur_stop);
    assign stat.lag_last    = (lag_reg == LAGC_W'(span_reg));
    assign stat.zero_energy = (sxx_reg == '0) || (syy_reg == '0);

    assign m_valid       = m_valid_reg;
    assign m_stop_index  = m_stop_reg;
    assign m_correlation = m_corr_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

endmodule
`default_nettype wire

// File: hdl/regional_cross_correlation.sv
// regional cross-correlation: top level joining sequencer and datapath
// Input beats on s_*: func load appends an (x, y) pair, query runs a row of
// correlations from start_index, clear empties the store; func 3 is dropped.
// Result beats on m_*: one beat per load (stored or store full), one per stop
// index of a query with last on the final one, or a single no-region beat.
// Configuration beats on cfg_*: index 0 lag_span, index 1 window_end; write
// only while the block is idle. cfg_ready is always high.
// A load captures the pair, then waits for the result register to be free.
// A query forms the two means in the shared divider; then, per stop index
// and per lag, it reads each sample (up to 16) through read, deviation,
// multiply and accumulate steps, takes two roots in the shared square root
// unit and divides in the shared divider, then divides for the average.
// One item is worked at a time; s_ready is high only between items.
// Reset empties the store (count and sums cleared), sets lag_span to 3 and
// window_end to 10. The store memory itself is not cleared and needs no pass.
// A stalled receiver holds the result register; the sequencer waits for it.
`default_nettype none
module regional_cross_correlation
    import rcc_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic        [FUNC_W-1:0]    s_func,
    input  wire logic signed [SAMPLE_W-1:0]  s_sample_x,
    input  wire logic signed [SAMPLE_W-1:0]  s_sample_y,
    input  wire logic        [ADDR_W-1:0]    s_start_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic             [ADDR_W-1:0]    m_stop_index,
    output logic signed      [CORR_W-1:0]    m_correlation,
    output logic             [STATUS_W-1:0]  m_status,
    output logic                             m_last,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [WIN_W-1:0]     cfg_data
);

    rcc_cmd_t  cmd;
    rcc_stat_t stat;

    assign cfg_ready = 1'b1;

    rcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_start_index (s_start_index),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stop_index  (m_stop_index),
        .m_correlation (m_correlation),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

// File: hdl/rcc_checker.sv
// port-level checks for the regional cross-correlation block, bound to the top level
`default_nettype none
module rcc_checker
    import rcc_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic [FUNC_W-1:0]   s_func,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [ADDR_W-1:0]   m_stop_index,
    input wire logic [CORR_W-1:0]   m_correlation,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic                m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_correlation)
                                && $stable(m_status) && $stable(m_stop_index))
        else $error("result beat changed while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_STORED || m_status == ST_FULL
                    || m_status == ST_NOREG) |-> m_last && m_stop_index == '0)
        else $error("single-beat result without last");

    a_zero_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ZERO |-> m_correlation == '0)
        else $error("zero energy beat with non-zero correlation");

    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FN_LOAD || s_func == FN_QUERY) |=> !s_ready)
        else $error("input taken while an item is in progress");

endmodule

bind regional_cross_correlation rcc_checker u_rcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_func        (s_func),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_stop_index  (m_stop_index),
    .m_correlation (m_correlation),
    .m_status      (m_status),
    .m_last        (m_last)
);
`default_nettype wire

// File: tb/regional_cross_correlation_tb.sv
// testbench for the regional cross-correlation block: self-checking, random and directed beats
`default_nettype none
module regional_cross_correlation_tb;
    import rcc_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0]          stop;
        logic signed [CORR_W-1:0]   corr;
        logic [STATUS_W-1:0]        status;
        logic                       last;
    } corr_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic        [FUNC_W-1:0]    s_func;
    logic signed [SAMPLE_W-1:0]  s_sample_x;
    logic signed [SAMPLE_W-1:0]  s_sample_y;
    logic        [ADDR_W-1:0]    s_start_index;
    logic                        m_valid;
    logic                        m_ready;
    logic        [ADDR_W-1:0]    m_stop_index;
    logic signed [CORR_W-1:0]    m_correlation;
    logic        [STATUS_W-1:0]  m_status;
    logic                        m_last;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [WIN_W-1:0]     cfg_data;

    // predictor state
    int          x_mem [0:MAX_SAMPLES-1];
    int          y_mem [0:MAX_SAMPLES-1];
    int unsigned count_pred;
    longint      sum_x_pred;
    longint      sum_y_pred;
    int unsigned lag_span_pred;
    int unsigned window_end_pred;

    corr_result_t pending_results[$];
    int errors;
    int results_seen;
    int loads_sent;
    int queries_sent;
    int send_idle_pct;
    int recv_idle_pct;

    regional_cross_correlation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_start_index (s_start_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stop_index  (m_stop_index),
        .m_correlation (m_correlation),
        .m_status      (m_status),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #1000000000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic longint mean_q8(longint sum, int unsigned n);
        longint unsigned mag;
        longint unsigned m;
        if (n == 0) return 0;
        mag = (sum < 0) ? -sum : sum;
        m = (mag * 512 + n) / (2 * longint'(n));
        return (sum < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // q1.15 correlation at one lag; returns 0 on zero energy
    function automatic bit lag_correlation(int unsigned s, int unsigned stop, int unsigned lag,
                                           longint mx, longint my, output longint val);
        longint sxx, syy, sxy, dx, dy;
        longint unsigned mag, den, q, rem;
        sxx = 0; syy = 0; sxy = 0;
        for (int unsigned i = s; i + lag <= stop; i++) begin
            dx = longint'(x_mem[i]) * 256 - mx;
            dy = longint'(y_mem[i + lag]) * 256 - my;
            sxx += dx * dx;
            syy += dy * dy;
            sxy += dx * dy;
        end
        val = 0;
        if (sxx == 0 || syy == 0) return 1'b0;
        den = floor_root(sxx) * floor_root(syy);
        mag = (sxy < 0) ? -sxy : sxy;
        q = mag / den;
        rem = mag % den;
        for (int k = 0; k < 16; k++) begin
            q = q << 1;
            rem = rem << 1;
            if (rem >= den) begin
                rem -= den;
                q++;
            end
        end
        q = (q + 1) >> 1;
        val = (sxy < 0) ? -longint'(q) : longint'(q);
        return 1'b1;
    endfunction

    function automatic void push_result(int unsigned stop, longint corr,
                                        logic [STATUS_W-1:0] st, logic lst);
        corr_result_t r;
        r.stop = stop[ADDR_W-1:0];
        r.corr = corr[CORR_W-1:0];
        r.status = st;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_row(int unsigned s);
        int unsigned span, stop, rows;
        longint mx, my, v, total;
        longint unsigned mag, n, m;
        bit ok;
        span = (lag_span_pred == 0) ? 1 : lag_span_pred;
        mx = mean_q8(sum_x_pred, count_pred);
        my = mean_q8(sum_y_pred, count_pred);
        rows = 0;
        for (int unsigned off = span; off <= window_end_pred; off++) begin
            stop = s + off;
            if (stop + 1 >= count_pred) break;
            total = 0;
            ok = 1'b1;
            for (int unsigned lag = 0; lag <= span; lag++) begin
                if (!lag_correlation(s, stop, lag, mx, my, v)) begin
                    ok = 1'b0;
                    break;
                end
                total += v;
            end
            if (!ok) begin
                push_result(stop, 0, ST_ZERO, 1'b0);
            end else begin
                n = span + 1;
                mag = (total < 0) ? -total : total;
                m = (2 * mag + n) / (2 * n);
                v = (total < 0) ? -longint'(m) : longint'(m);
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                push_result(stop, v, ST_VALUE, 1'b0);
            end
            rows++;
        end
        if (rows == 0) push_result(0, 0, ST_NOREG, 1'b1);
        else pending_results[$].last = 1'b1;
    endfunction

    function automatic void predict_beat(logic [FUNC_W-1:0] fn, int x, int y, int unsigned s);
        case (fn)
            FN_LOAD: begin
                if (count_pred >= MAX_SAMPLES) begin
                    push_result(0, 0, ST_FULL, 1'b1);
                end else begin
                    x_mem[count_pred] = x;
                    y_mem[count_pred] = y;
                    sum_x_pred += x;
                    sum_y_pred += y;
                    count_pred++;
                    push_result(0, 0, ST_STORED, 1'b1);
                end
            end
            FN_CLEAR: begin
                count_pred = 0;
                sum_x_pred = 0;
                sum_y_pred = 0;
            end
            FN_QUERY: predict_row(s);
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        corr_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result stop %0d corr %0d status %0d last %0b",
                         $time, m_stop_index, m_correlation, m_status, m_last);
            end else begin
                e = pending_results.pop_front();
                if (m_stop_index !== e.stop) begin
                    errors++;
                    $display("%0t: stop_index expected %0d actual %0d",
                             $time, e.stop, m_stop_index);
                end
                if (m_correlation !== e.corr) begin
                    errors++;
                    $display("%0t: correlation expected %0d actual %0d (stop %0d)",
                             $time, e.corr, m_correlation, e.stop);
                end
                if (m_status !== e.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d (stop %0d)",
                             $time, e.status, m_status, e.stop);
                end
                if (m_last !== e.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b (stop %0d)",
                             $time, e.last, m_last, e.stop);
                end
            end
        end
    end

    // one input beat, entered and left at a falling edge
    task automatic send_beat(logic [FUNC_W-1:0] fn, int x, int y, int unsigned s);
        if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(1, 4)) @(negedge aclk);
        s_valid = 1'b1;
        s_func = fn;
        s_sample_x = x[SAMPLE_W-1:0];
        s_sample_y = y[SAMPLE_W-1:0];
        s_start_index = s[ADDR_W-1:0];
        do @(posedge aclk); while (!s_ready);
        predict_beat(fn, int'(s_sample_x), int'(s_sample_y), s);
        if (fn == FN_LOAD) loads_sent++;
        if (fn == FN_QUERY) queries_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[WIN_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_LAG_SPAN) lag_span_pred = val & 7;
        else window_end_pred = val & 15;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_window(int unsigned span, int unsigned wend);
        wait_idle();
        write_reg(CFG_LAG_SPAN, span);
        write_reg(CFG_WINDOW_END, wend);
    endtask

    task automatic load_run(int n, int mode);
        int x, y;
        for (int k = 0; k < n; k++) begin
            x = $signed(16'($urandom));
            case (mode)
                0: y = $signed(16'($urandom));
                1: begin
                    x = $urandom_range(0, 40) - 20;
                    y = $urandom_range(0, 40) - 20;
                end
                2: y = (x / 2) + int'($urandom_range(0, 2000)) - 1000;
                default: y = -(x / 2) + int'($urandom_range(0, 200)) - 100;
            endcase
            send_beat(FN_LOAD, x, y, 0);
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // default registers, empty store
        send_beat(FN_QUERY, 0, 0, 0);
        send_beat(FN_LOAD, 32767, -32768, 0);
        send_beat(FN_LOAD, -32768, 32767, 0);
        send_beat(FN_LOAD, 0, 0, 0);
        send_beat(FN_LOAD, -1, -1, 0);
        send_beat(FN_LOAD, 32767, 32767, 0);
        send_beat(FN_QUERY, 0, 0, 0);
        send_beat(FN_UNUSED, 123, -5, 77);
        send_beat(FN_CLEAR, 0, 0, 0);
        // flat data has no energy
        for (int k = 0; k < 14; k++) send_beat(FN_LOAD, 5, -7, 0);
        send_beat(FN_QUERY, 0, 0, 0);
        send_beat(FN_QUERY, 0, 0, 65535);
        send_beat(FN_CLEAR, 0, 0, 0);
        load_run(18, 2);
        send_beat(FN_QUERY, 0, 0, 1);
        set_window(0, 2);
        send_beat(FN_QUERY, 0, 0, 0);
        set_window(7, 15);
        send_beat(FN_QUERY, 0, 0, 0);
        set_window(5, 3);
        send_beat(FN_QUERY, 0, 0, 0);
    endtask

    task automatic test_random_phase(int sender_pct, int receiver_pct, int beats);
        int sent, n, nq;
        int unsigned s;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < beats) begin
            case ($urandom_range(0, 3))
                0: set_window($urandom_range(0, 7), $urandom_range(2, 15));
                1: set_window($urandom_range(0, 1) ? 1 : 7, $urandom_range(0, 1) ? 2 : 15);
                default: set_window($urandom_range(1, 4), $urandom_range(4, 8));
            endcase
            if ($urandom_range(99) < 70 || count_pred > 200) begin
                send_beat(FN_CLEAR, 0, 0, 0);
                sent++;
            end
            n = $urandom_range(2, 24);
            load_run(n, $urandom_range(0, 3));
            sent += n;
            nq = $urandom_range(1, 3);
            for (int k = 0; k < nq; k++) begin
                if ($urandom_range(99) < 85) s = $urandom_range(0, count_pred);
                else s = $urandom_range(0, 65535);
                send_beat(FN_QUERY, 0, 0, s);
                sent++;
            end
            if ($urandom_range(99) < 15) begin
                send_beat(FN_UNUSED, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_high_start();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(3, 10);
        send_beat(FN_CLEAR, 0, 0, 0);
        load_run(12, 3);
        send_beat(FN_QUERY, 0, 0, 0);
        send_beat(FN_QUERY, 0, 0, MAX_SAMPLES - 8);
        send_beat(FN_QUERY, 0, 0, MAX_SAMPLES - 1);
        send_beat(FN_CLEAR, 0, 0, 0);
        send_beat(FN_QUERY, 0, 0, 0);
    endtask

    initial begin
        errors = 0;
        results_seen = 0;
        loads_sent = 0;
        queries_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        count_pred = 0;
        sum_x_pred = 0;
        sum_y_pred = 0;
        lag_span_pred = LAG_SPAN_RESET;
        window_end_pred = WINDOW_END_RESET;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FN_LOAD;
        s_sample_x = '0;
        s_sample_y = '0;
        s_start_index = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAG_SPAN;
        cfg_data = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_phase(22, 66, 85);
        test_random_phase(66, 22, 85);
        test_random_phase(0, 0, 85);
        test_high_start();

        wait_idle();
        repeat (50) @(negedge aclk);
        $display("covered %0d loads and %0d queries, %0d results checked",
                 loads_sent, queries_sent, results_seen);
        $display("lag/window extremes, zero energy, empty regions, unused func, late starts");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
